@@ hw/rtl/keypad_code_lock_unit_assert.svh @@
// Assertion macros for the keypad code lock unit.
`ifndef KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kcl_pkg.sv @@
// Shared constants and codes for the keypad code lock unit.
package kcl_pkg;

    // Sizing of the keypad and the code.
    localparam int MAX_CODE_KEYS = 8;
    localparam int KEY_COLUMNS   = 4;

    // Fixed field widths.
    localparam int KEY_W     = 4;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTERED_W = 4;
    localparam int LEN_W     = 4;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Entry counter holds 0..MAX_CODE_KEYS, buffer index addresses the entries.
    localparam int CNT_W = $clog2(MAX_CODE_KEYS + 1);
    localparam int IDX_W = (MAX_CODE_KEYS > 1) ? $clog2(MAX_CODE_KEYS) : 1;

    // Special keys, row 3 of the pad.
    localparam logic [7:0] KEY_STAR = 8'(3 * KEY_COLUMNS + 0);
    localparam logic [7:0] KEY_HASH = 8'(3 * KEY_COLUMNS + 2);

    // Input word kinds.
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_KEYS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic [WORD_W-1:0] RST_CODE_KEYS     = 32'd0;
    localparam logic [LEN_W-1:0]  RST_CODE_LENGTH   = 4'd4;
    localparam logic [WORD_W-1:0] RST_TIMEOUT_TICKS = 32'd30000;

endpackage

@@ hw/rtl/kcl_in_if.sv @@
// Input channel carrying one keypad event word.
interface kcl_in_if import kcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

@@ hw/rtl/kcl_out_if.sv @@
// Output channel carrying one lock result word.
interface kcl_out_if import kcl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ENTERED_W-1:0] entered_count;
    logic                 session_active;

    modport source (output valid, output status, output entered_count,
                    output session_active, input ready);
    modport sink   (input valid, input status, input entered_count,
                    input session_active, output ready);
endinterface

@@ hw/rtl/kcl_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface kcl_cfg_if import kcl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/keypad_code_lock_unit.sv @@
// An input word is first captured in the input register; its result word is then
// written to the result register, from which it is taken.
// Throughput: one word per cycle while the result channel is not stalled; an input
// register feeds a single stage of compare and update logic that writes the session
// state and the result register. A stalled result holds the input register, which
// holds the input channel. Reset (synchronous, active low) ends any session, empties
// the entry count, zeroes the tick count and loads the configuration reset values.
module keypad_code_lock_unit import kcl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcl_in_if.sink    i_in,
    kcl_out_if.source o_out,
    kcl_cfg_if.sink   i_cfg
);

    `include "keypad_code_lock_unit_assert.svh"

    // Configuration registers.
    logic [WORD_W-1:0] r_code_keys;
    logic [LEN_W-1:0]  r_code_len;
    logic [WORD_W-1:0] r_timeout;

    // Input register.
    logic              r_in_valid;
    logic [KIND_W-1:0] r_in_kind;
    logic [KEY_W-1:0]  r_in_key;

    // Session state.
    logic [KEY_W-1:0]  r_buf [MAX_CODE_KEYS];
    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_elapsed;
    logic              r_active;

    // Result register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_active;

    // Next values and datapath signals.
    logic                advance;
    logic                fire;
    logic [CNT_W-1:0]    eff_len;
    logic                match;
    logic [WORD_W-1:0]   elapsed_inc;
    logic [WORD_W-1:0]   elapsed_cmp;
    logic                timed_out;
    logic                store_en;
    logic [CNT_W-1:0]    n_count;
    logic [WORD_W-1:0]   n_elapsed;
    logic                n_active;
    logic [STATUS_W-1:0] n_status;

    // Handshakes: the result register frees the stage, the stage frees the input.
    assign advance     = !r_out_valid || o_out.ready;
    assign fire        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_keys <= RST_CODE_KEYS;
            r_code_len  <= RST_CODE_LENGTH;
            r_timeout   <= RST_TIMEOUT_TICKS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CODE_KEYS:     r_code_keys <= i_cfg.data;
                CFG_CODE_LENGTH:   r_code_len  <= i_cfg.data[LEN_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout   <= i_cfg.data;
                default:           ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_key  <= i_in.key;
        end
    end

    // Code length clamped to the buffer depth.
    always_comb begin
        if ({1'b0, r_code_len} > (LEN_W + 1)'(MAX_CODE_KEYS)) begin
            eff_len = CNT_W'(MAX_CODE_KEYS);
        end else begin
            eff_len = CNT_W'(r_code_len);
        end
    end

    // Entry compare: length must agree, then each used position in parallel.
    always_comb begin
        match = (r_count == eff_len);
        for (int i = 0; i < MAX_CODE_KEYS; i++) begin
            if ((CNT_W'(i) < eff_len) && (r_buf[i] != KEY_W'(r_code_keys >> (KEY_W * i)))) begin
                match = 1'b0;
            end
        end
    end

    // Saturating tick count and the timeout compare it shares with key handling.
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + WORD_W'(1);
    assign elapsed_cmp = (r_in_kind == KIND_TICK) ? elapsed_inc : r_elapsed;
    assign timed_out   = (elapsed_cmp >= r_timeout);

    // Per-word session update.
    always_comb begin
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_active  = r_active;
        n_status  = ST_NOTHING;
        store_en  = 1'b0;
        case (r_in_kind)
            KIND_START: begin
                n_count   = '0;
                n_elapsed = '0;
                if (r_timeout == '0) begin
                    n_active = 1'b0;
                    n_status = ST_TIMEOUT;
                end else begin
                    n_active = 1'b1;
                end
            end
            KIND_KEY: begin
                if (r_active) begin
                    if (timed_out) begin
                        n_active = 1'b0;
                        n_status = ST_TIMEOUT;
                    end else if (8'(r_in_key) == KEY_HASH) begin
                        if (match) begin
                            n_active = 1'b0;
                            n_status = ST_ACCEPTED;
                        end else begin
                            n_count  = '0;
                            n_status = ST_WRONG;
                        end
                    end else if (8'(r_in_key) == KEY_STAR) begin
                        n_count  = '0;
                        n_status = ST_CLEARED;
                    end else if (r_count < eff_len) begin
                        store_en = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                        n_status = ST_STORED;
                    end
                end
            end
            KIND_TICK: begin
                if (r_active) begin
                    n_elapsed = elapsed_inc;
                    if (timed_out) begin
                        n_active = 1'b0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    // Session state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_elapsed <= '0;
            r_active  <= 1'b0;
        end else if (fire) begin
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_active  <= n_active;
        end
    end

    // Entry buffer; positions at or above the clamped code length are never compared.
    always_ff @(posedge i_clk) begin
        if (fire && store_en) begin
            r_buf[r_count[IDX_W-1:0]] <= r_in_key;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_active <= n_active;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.entered_count  = ENTERED_W'(r_out_count);
    assign o_out.session_active = r_out_active;

    // Checks on the lock logic.
    `KCL_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_CODE_KEYS), "entry count above cap")
    `KCL_ASSERT_NOW(a_accept_ends, r_out_valid && (r_out_status == ST_ACCEPTED), !r_out_active, "accept left session open")
    `KCL_ASSERT_NOW(a_stored_nonzero, r_out_valid && (r_out_status == ST_STORED), r_out_count != '0, "stored key with empty buffer")
    `KCL_ASSERT_NEXT(a_fire_result, fire, r_out_valid, "processed word produced no result")

endmodule
